### hdl/rbvi_pkg.sv
// Package for the rigid body integrator: formats, operation codes and register indexes.
package rbvi_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int W = 32;
    localparam int DT_W = 16;
    localparam int OP_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_FORCE   = 3'd1;
    localparam logic [OP_W-1:0] OP_IMPULSE = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd3;
    localparam logic [OP_W-1:0] OP_SETVEL  = 3'd4;
    localparam logic [OP_W-1:0] OP_SETPOS  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MASS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMMOV   = 2'd2;

    typedef logic signed [W-1:0] t_word;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic t_word sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = t_word'(x[W-1:0]);
        end
    endfunction
endpackage

### hdl/rbvi_div.sv
// Restoring divider: signed dividend by unsigned divisor, quotient truncated toward zero.
module rbvi_div #(
    parameter int FRAC_BITS = rbvi_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [rbvi_pkg::W-1:0] i_num,
    input  logic [rbvi_pkg::W-1:0]      i_den,
    output logic                        o_done,
    output logic signed [64:0]          o_quot
);
    import rbvi_pkg::*;
    localparam int NW = W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [W:0]    r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_neg;
    logic [W:0]    n_rem;
    logic [W:0]    w_try;
    logic [W-1:0]  w_mag;

    assign w_mag = i_num[W-1] ? W'(-i_num) : W'(i_num);
    assign n_rem = {r_rem[W-1:0], r_q[NW-1]};
    assign w_try = n_rem - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= {w_mag, {FRAC_BITS{1'b0}}};
                r_rem  <= '0;
                r_neg  <= i_num[W-1];
            end else if (r_busy) begin
                if (!w_try[W]) begin
                    r_rem <= w_try;
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_neg ? -$signed({17'd0, r_q}) : $signed({17'd0, r_q});
endmodule

### hdl/rigid_body_verlet_integrator.sv
// Top level of the rigid body velocity Verlet integrator.
// A tick on a movable body runs, per axis, the serial divider and seven other steps before
// its result word is presented; an impulse with nonzero mass runs the divider per axis;
// other operations present their result word directly.
// Throughput: one word at a time; the input is stalled until the result word is taken.
// Reset (synchronous, active low) zeroes pos, vel, force, accel and gravity; mass to 1.0.
module rigid_body_verlet_integrator #(
    parameter int FRAC_BITS = rbvi_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rbvi_pkg::OP_W-1:0]       i_operation,
    input  logic signed [rbvi_pkg::W-1:0]   i_vec_x,
    input  logic signed [rbvi_pkg::W-1:0]   i_vec_y,
    input  logic signed [rbvi_pkg::W-1:0]   i_vec_z,
    input  logic [rbvi_pkg::DT_W-1:0]       i_delta_time,
    input  logic                            i_cfg_we,
    input  logic [rbvi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbvi_pkg::W-1:0]          i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [rbvi_pkg::W-1:0]   o_pos_x,
    output logic signed [rbvi_pkg::W-1:0]   o_pos_y,
    output logic signed [rbvi_pkg::W-1:0]   o_pos_z,
    output logic signed [rbvi_pkg::W-1:0]   o_vel_x,
    output logic signed [rbvi_pkg::W-1:0]   o_vel_y,
    output logic signed [rbvi_pkg::W-1:0]   o_vel_z,
    output logic signed [rbvi_pkg::W-1:0]   o_disp_x,
    output logic signed [rbvi_pkg::W-1:0]   o_disp_y,
    output logic signed [rbvi_pkg::W-1:0]   o_disp_z
);
    import rbvi_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MV    = 4'd1;  // v*dt product
    localparam logic [3:0] S_MA    = 4'd2;  // a*dt product
    localparam logic [3:0] S_MA2   = 4'd3;  // (a*dt)*dt product
    localparam logic [3:0] S_DISP  = 4'd4;  // displacement and position
    localparam logic [3:0] S_DIVS  = 4'd5;  // start the division
    localparam logic [3:0] S_DIVW  = 4'd6;  // wait for the quotient
    localparam logic [3:0] S_MAVG  = 4'd7;  // avg*dt product
    localparam logic [3:0] S_VEL   = 4'd8;  // velocity update, next axis
    localparam logic [3:0] S_IMPS  = 4'd9;  // impulse: start division
    localparam logic [3:0] S_IMPW  = 4'd10; // impulse: wait, next axis
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] r_state;
    logic [1:0] r_ax;
    t_word r_pos [3];
    t_word r_vel [3];
    t_word r_frc [3];
    t_word r_avg [3];
    t_word r_lst [3];
    t_word r_new [3];
    t_word r_disp [3];
    t_word r_vec [3];
    logic [W-1:0] r_mass;
    t_word r_grav;
    logic r_immov;
    logic [DT_W-1:0] r_dt;
    logic signed [65:0] r_prod;   // registered multiplier output
    logic signed [65:0] r_vterm;  // rounded v*dt term

    // Shared multiplier: a signed 49-bit operand by dt taken as a positive 17-bit value.
    // The a*dt*dt term is formed as (a*dt)*dt, the exact a*dt product being fed back in.
    logic signed [48:0] w_ma;
    logic signed [16:0] w_mb;
    logic signed [65:0] w_mul;
    assign w_mb  = $signed({1'b0, r_dt});
    assign w_mul = 66'(w_ma) * 66'(w_mb);

    // Divider shared between tick and impulse.
    logic w_div_start;
    t_word w_div_num;
    logic w_div_done;
    logic signed [64:0] w_quot;

    rbvi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (r_mass),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_div_start = (r_state == S_DIVS) || (r_state == S_IMPS);
    assign w_div_num   = (r_state == S_IMPS) ? r_vec[r_ax] : r_frc[r_ax];

    always_comb begin
        case (r_state)
            S_MV:    w_ma = 49'(r_vel[r_ax]);
            S_MA:    w_ma = 49'(r_avg[r_ax]);
            S_MA2:   w_ma = r_prod[48:0];
            S_MAVG:  w_ma = 49'(r_avg[r_ax]);
            default: w_ma = 49'(r_vel[r_ax]);
        endcase
    end

    logic signed [65:0] w_aterm;
    logic signed [65:0] w_vr;
    logic signed [65:0] w_disp;
    logic signed [65:0] w_qy;
    t_word w_na;
    t_word w_avgn;
    assign w_aterm = (r_prod + 66'sd4294967296) >>> 33;
    assign w_vr    = (r_prod + 66'sd32768) >>> 16;
    assign w_disp  = r_vterm + w_aterm;
    assign w_qy    = 66'(w_quot) - ((r_ax == 2'd1) ? 66'(r_grav) : 66'sd0);
    assign w_na    = (r_mass == '0) ? t_word'(0) : sat32(w_qy);
    assign w_avgn  = t_word'((33'(r_lst[r_ax]) + 33'(w_na)) >>> 1);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= '0;
            r_mass  <= W'(1) << FRAC_BITS;
            r_grav  <= '0;
            r_immov <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0; r_vel[i] <= '0; r_frc[i] <= '0;
                r_avg[i] <= '0; r_lst[i] <= '0; r_new[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MASS:    r_mass  <= i_cfg_data;
                    REG_GRAVITY: r_grav  <= t_word'(i_cfg_data);
                    REG_IMMOV:   r_immov <= i_cfg_data[0];
                    default:     ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_vec[0] <= i_vec_x; r_vec[1] <= i_vec_y; r_vec[2] <= i_vec_z;
                        r_dt <= i_delta_time;
                        r_ax <= '0;
                        for (int i = 0; i < 3; i++) r_disp[i] <= '0;
                        if (i_operation == OP_TICK && !r_immov) begin
                            r_state <= S_MV;
                        end else if (i_operation == OP_IMPULSE && r_mass != '0) begin
                            r_state <= S_IMPS;
                        end else begin
                            r_state <= S_OUT;
                        end
                        case (i_operation)
                            OP_FORCE: for (int i = 0; i < 3; i++)
                                r_frc[i] <= sat32(66'(r_frc[i]) + 66'(
                                    i == 0 ? i_vec_x : (i == 1 ? i_vec_y : i_vec_z)));
                            OP_RESET: for (int i = 0; i < 3; i++) begin
                                r_frc[i] <= '0; r_vel[i] <= '0;
                                r_avg[i] <= '0; r_new[i] <= '0;
                            end
                            OP_SETVEL: begin
                                r_vel[0] <= i_vec_x; r_vel[1] <= i_vec_y;
                                r_vel[2] <= i_vec_z;
                            end
                            OP_SETPOS: begin
                                r_pos[0] <= i_vec_x; r_pos[1] <= i_vec_y;
                                r_pos[2] <= i_vec_z;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MV: begin
                    r_prod  <= w_mul;
                    r_state <= S_MA;
                end
                S_MA: begin
                    r_vterm <= w_vr;
                    r_prod  <= w_mul;
                    r_lst[r_ax] <= r_avg[r_ax];
                    r_state <= S_MA2;
                end
                S_MA2: begin
                    r_prod  <= w_mul;
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    r_disp[r_ax] <= sat32(w_disp);
                    r_pos[r_ax]  <= sat32(66'(r_pos[r_ax]) + 66'(sat32(w_disp)));
                    r_state <= S_DIVS;
                end
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: if (w_div_done) begin
                    r_new[r_ax] <= w_na;
                    r_avg[r_ax] <= w_avgn;
                    r_state <= S_MAVG;
                end
                S_MAVG: begin
                    r_prod  <= w_mul;
                    r_state <= S_VEL;
                end
                S_VEL: begin
                    r_vel[r_ax] <= sat32(66'(r_vel[r_ax]) + w_vr);
                    if (r_ax == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_MV;
                    end
                end
                S_IMPS: r_state <= S_IMPW;
                S_IMPW: if (w_div_done) begin
                    r_vel[r_ax] <= sat32(66'(r_vel[r_ax]) + 66'(w_quot));
                    if (r_ax == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_IMPS;
                    end
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pos_x  = r_pos[0];
    assign o_pos_y  = r_pos[1];
    assign o_pos_z  = r_pos[2];
    assign o_vel_x  = r_vel[0];
    assign o_vel_y  = r_vel[1];
    assign o_vel_z  = r_vel[2];
    assign o_disp_x = r_disp[0];
    assign o_disp_y = r_disp[1];
    assign o_disp_z = r_disp[2];

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_vel_x))
        else $error("result word changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result waits");
    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ax != 2'd3)
        else $error("axis counter out of range");
endmodule

### tb/rbvi_checker.sv
// Checker for the rigid body integrator: predicts each result word and compares it.
`timescale 1ns / 100ps
module rbvi_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic [rbvi_pkg::OP_W-1:0]      i_operation,
    input  logic signed [31:0]             i_vec_x,
    input  logic signed [31:0]             i_vec_y,
    input  logic signed [31:0]             i_vec_z,
    input  logic [15:0]                    i_delta_time,
    input  logic                           i_cfg_we,
    input  logic [rbvi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic signed [31:0]             o_pos_x,
    input  logic signed [31:0]             o_pos_y,
    input  logic signed [31:0]             o_pos_z,
    input  logic signed [31:0]             o_vel_x,
    input  logic signed [31:0]             o_vel_y,
    input  logic signed [31:0]             o_vel_z,
    input  logic signed [31:0]             o_disp_x,
    input  logic signed [31:0]             o_disp_y,
    input  logic signed [31:0]             o_disp_z,
    output int                             o_fail_count,
    output int                             o_pending
);
    import rbvi_pkg::*;

    typedef struct packed {
        logic signed [31:0] px, py, pz, vx, vy, vz, dx, dy, dz;
    } t_motion;

    t_motion motion_q[$];
    longint pos[3], vel[3], net_f[3], avg_acc[3], last_acc[3], new_acc[3];
    longint mass, grav;
    bit immov;

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fdiv2n(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint rnd2n(longint x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint mass_quot(longint x);
        return (x * 65536) / mass;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic apply_word(logic [2:0] op, longint v[3], longint dt);
        longint disp[3];
        t_motion m;
        for (int i = 0; i < 3; i++) disp[i] = 0;
        case (op)
            OP_TICK: if (!immov) begin
                for (int i = 0; i < 3; i++) begin
                    last_acc[i] = avg_acc[i];
                    disp[i] = clamp32(rnd2n(vel[i] * dt, 16) + rnd2n(last_acc[i] * dt * dt, 33));
                    pos[i] = clamp32(pos[i] + disp[i]);
                end
                if (mass == 0) begin
                    for (int i = 0; i < 3; i++) new_acc[i] = 0;
                end else begin
                    new_acc[0] = clamp32(mass_quot(net_f[0]));
                    new_acc[1] = clamp32(mass_quot(net_f[1]) - grav);
                    new_acc[2] = clamp32(mass_quot(net_f[2]));
                end
                for (int i = 0; i < 3; i++) begin
                    avg_acc[i] = fdiv2n(last_acc[i] + new_acc[i], 1);
                    vel[i] = clamp32(vel[i] + rnd2n(avg_acc[i] * dt, 16));
                end
            end
            OP_FORCE: for (int i = 0; i < 3; i++) net_f[i] = clamp32(net_f[i] + v[i]);
            OP_IMPULSE: if (mass != 0) begin
                for (int i = 0; i < 3; i++) vel[i] = clamp32(vel[i] + mass_quot(v[i]));
            end
            OP_RESET: for (int i = 0; i < 3; i++) begin
                net_f[i] = 0; vel[i] = 0; avg_acc[i] = 0; new_acc[i] = 0;
            end
            OP_SETVEL: for (int i = 0; i < 3; i++) vel[i] = v[i];
            OP_SETPOS: for (int i = 0; i < 3; i++) pos[i] = v[i];
            default: ;
        endcase
        m.px = 32'(pos[0]); m.py = 32'(pos[1]); m.pz = 32'(pos[2]);
        m.vx = 32'(vel[0]); m.vy = 32'(vel[1]); m.vz = 32'(vel[2]);
        m.dx = 32'(disp[0]); m.dy = 32'(disp[1]); m.dz = 32'(disp[2]);
        motion_q = {motion_q, m};
    endtask

    always @(posedge i_clk) begin
        longint v[3];
        t_motion e;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                pos[i] = 0; vel[i] = 0; net_f[i] = 0;
                avg_acc[i] = 0; last_acc[i] = 0; new_acc[i] = 0;
            end
            mass = 65536; grav = 0; immov = 0;
            motion_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MASS:    mass = {32'd0, i_cfg_data};
                    REG_GRAVITY: grav = longint'($signed(i_cfg_data));
                    REG_IMMOV:   immov = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                v[0] = longint'(i_vec_x); v[1] = longint'(i_vec_y); v[2] = longint'(i_vec_z);
                apply_word(i_operation, v, {48'd0, i_delta_time});
            end
            if (o_valid && !i_stall) begin
                if (motion_q.size() == 0) begin
                    report_mismatch("unexpected result word", 1, 0);
                end else begin
                    e = motion_q.pop_front();
                    if (o_pos_x !== e.px)
                        report_mismatch("pos_x", longint'(o_pos_x), longint'(e.px));
                    if (o_pos_y !== e.py)
                        report_mismatch("pos_y", longint'(o_pos_y), longint'(e.py));
                    if (o_pos_z !== e.pz)
                        report_mismatch("pos_z", longint'(o_pos_z), longint'(e.pz));
                    if (o_vel_x !== e.vx)
                        report_mismatch("vel_x", longint'(o_vel_x), longint'(e.vx));
                    if (o_vel_y !== e.vy)
                        report_mismatch("vel_y", longint'(o_vel_y), longint'(e.vy));
                    if (o_vel_z !== e.vz)
                        report_mismatch("vel_z", longint'(o_vel_z), longint'(e.vz));
                    if (o_disp_x !== e.dx)
                        report_mismatch("disp_x", longint'(o_disp_x), longint'(e.dx));
                    if (o_disp_y !== e.dy)
                        report_mismatch("disp_y", longint'(o_disp_y), longint'(e.dy));
                    if (o_disp_z !== e.dz)
                        report_mismatch("disp_z", longint'(o_disp_z), longint'(e.dz));
                end
            end
        end
        o_pending = motion_q.size();
    end
endmodule

### tb/testbench.sv
// Testbench top for the rigid body integrator: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module testbench;
    import rbvi_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [OP_W-1:0] i_operation = OP_TICK;
    logic signed [W-1:0] i_vec_x = '0, i_vec_y = '0, i_vec_z = '0;
    logic [DT_W-1:0] i_delta_time = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_MASS;
    logic [W-1:0] i_cfg_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [W-1:0] o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z;
    logic signed [W-1:0] o_disp_x, o_disp_y, o_disp_z;
    int fail_count, pending;

    // When set, neither side inserts random waits; this gives a long stretch at full pressure.
    bit busy_stretch = 1'b0;

    always #2 i_clk = ~i_clk;

    rigid_body_verlet_integrator i_dut (.*);

    rbvi_checker i_checker (.*, .o_fail_count(fail_count), .o_pending(pending));

    // The receiver stalls in about a third of cycles, except in the busy stretch.
    always @(posedge i_clk) begin
        i_stall <= !busy_stretch && ($urandom_range(99) < 32);
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(2000000)) - 1000000);
            3: return 32'($signed($urandom_range(600)) - 300) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // Offers one word and holds it until it has been taken.
    task automatic send_word(logic [OP_W-1:0] op, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [15:0] dt);
        if (!busy_stretch) begin
            while ($urandom_range(99) < 32) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_vec_x <= x; i_vec_y <= y; i_vec_z <= z;
        i_delta_time <= dt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every expected word, then lets the block settle before a register write.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_words(int count);
        int op;
        for (int n = 0; n < count; n++) begin
            op = $urandom_range(99);
            // Mostly force and tick sequences so the motion really develops.
            if (op < 40) send_word(OP_TICK, $urandom, $urandom, $urandom, 16'($urandom));
            else if (op < 62) send_word(OP_FORCE, rand_word(), rand_word(), rand_word(), 16'($urandom));
            else if (op < 72) send_word(OP_IMPULSE, rand_word(), rand_word(), rand_word(), 16'($urandom));
            else if (op < 78) send_word(OP_RESET, $urandom, $urandom, $urandom, 16'($urandom));
            else if (op < 86) send_word(OP_SETVEL, rand_word(), rand_word(), rand_word(), 16'($urandom));
            else if (op < 94) send_word(OP_SETPOS, rand_word(), rand_word(), rand_word(), 16'($urandom));
            else send_word(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom, 16'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: every operation, field extremes, unused codes, zero and maximum steps.
        send_word(OP_FORCE, 32'h00010000, 32'h00020000, 32'hFFFF0000, 16'h0000);
        send_word(OP_TICK, 0, 0, 0, 16'hFFFF);
        send_word(OP_TICK, 0, 0, 0, 16'h0000);
        send_word(OP_SETVEL, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 16'hFFFF);
        send_word(OP_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        send_word(OP_SETPOS, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'h0000);
        send_word(OP_TICK, 0, 0, 0, 16'h8000);
        send_word(OP_FORCE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h0);
        send_word(OP_FORCE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h0);
        send_word(OP_TICK, 0, 0, 0, 16'hFFFF);
        send_word(OP_IMPULSE, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 16'h0);
        send_word(3'd6, 32'hFFFFFFFF, 0, 0, 16'hFFFF);
        send_word(3'd7, 0, 32'hFFFFFFFF, 0, 16'h0);
        send_word(OP_RESET, 0, 0, 0, 16'h0);
        send_word(OP_TICK, 0, 0, 0, 16'h1234);

        // Phase settings: zero mass, tiny and huge mass, gravity extremes, immovable body.
        drain();
        write_reg(REG_MASS, 32'h0);
        write_reg(REG_GRAVITY, 32'h80000000);
        write_reg(2'd3, 32'hFFFFFFFF);
        send_word(OP_FORCE, 32'h00050000, 32'h00050000, 32'h00050000, 16'h0);
        send_word(OP_IMPULSE, 32'h00050000, 32'h00050000, 32'h00050000, 16'h0);
        send_word(OP_TICK, 0, 0, 0, 16'hFFFF);
        random_words(100);

        drain();
        write_reg(REG_MASS, 32'h1);
        write_reg(REG_GRAVITY, 32'h7FFFFFFF);
        random_words(150);

        drain();
        write_reg(REG_MASS, 32'hFFFFFFFF);
        write_reg(REG_GRAVITY, 32'hFFF63000);
        write_reg(REG_IMMOV, 32'h1);
        send_word(OP_TICK, 0, 0, 0, 16'hFFFF);
        random_words(100);

        drain();
        write_reg(REG_IMMOV, 32'h0);
        write_reg(REG_MASS, 32'h00020000);
        write_reg(REG_GRAVITY, 32'h0009CE00);
        busy_stretch = 1'b1;
        random_words(250);
        busy_stretch = 1'b0;

        // Sender holds off until every expected word has arrived.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        random_words(200);

        drain();
        write_reg(REG_MASS, $urandom);
        write_reg(REG_GRAVITY, $urandom);
        random_words(400);

        drain();
        if (fail_count == 0) begin
            $display("rigid_body_verlet_integrator verification clean");
        end else begin
            $display("rigid_body_verlet_integrator verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("rigid_body_verlet_integrator verification failed");
        $finish;
    end
endmodule
